### rtl/core/field_mill_roll_rotation_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the field mill roll rotation block.
// These expand to concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIELD_MILL_ROLL_ROTATION_DEFINES_SVH
`define FIELD_MILL_ROLL_ROTATION_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while the reset is released.
`define FMRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, including during reset.
`define FMRR_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FMRR_ASSERT(lbl, prop, msg)
`define FMRR_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

### rtl/core/fmrr_pkg.sv
// ----------------------------------------------------------------------------
// fmrr_pkg
// Types, register codes and constant tables of the roll rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package fmrr_pkg;

  // Configuration registers.
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 4;
  localparam int unsigned REG_SEL_W = 3;

  localparam int unsigned REG_RATIO_FIELD_Y = 0;
  localparam int unsigned REG_GAIN_FIELD_Y  = 1;
  localparam int unsigned REG_RATIO_FIELD_Z = 2;
  localparam int unsigned REG_GAIN_FIELD_Z  = 3;
  localparam int unsigned REG_RATIO_AUX_Y   = 4;
  localparam int unsigned REG_GAIN_AUX_Y    = 5;
  localparam int unsigned REG_RATIO_AUX_Z   = 6;
  localparam int unsigned REG_GAIN_AUX_Z    = 7;

  localparam logic [15:0] CFG_RESET [NUM_REGS] = '{
    16'd7905, 16'd1188, 16'd3031, 16'd1188, 16'd4260, 16'd2294, 16'd3940, 16'd2294
  };

  typedef logic [NUM_REGS-1:0][15:0] fmrr_cfg_t;

  // Word widths.
  localparam int unsigned IN_W   = 336;
  localparam int unsigned OUT_W  = 192;
  localparam int unsigned TERM_W = 40;
  localparam int unsigned CS_W   = 20;
  localparam int unsigned ANG_W  = 34;

  // Pair terms: field y, field z, aux y, aux z. The first reading of each pair
  // is weighted against the second.
  localparam int unsigned NUM_PAIRS = 4;
  localparam int unsigned PAIR_A_LSB [NUM_PAIRS] = '{144, 80, 272, 208};
  localparam int unsigned PAIR_B_LSB [NUM_PAIRS] = '{176, 112, 304, 240};

  // Angle conversion: 2^32 = 36000 * TURN_Q + TURN_R.
  localparam logic [16:0] ANGLE_HALF    = 17'd18000;
  localparam logic [16:0] ANGLE_FULL    = 17'd36000;
  localparam logic [16:0] ANGLE_QUARTER = 17'd9000;
  localparam logic [16:0] TURN_Q        = 17'd119304;
  localparam logic [14:0] TURN_R        = 15'd23296;
  localparam logic [24:0] RECIP_M       = 25'd30541989;

  localparam logic [ANG_W-1:0] CORDIC_X0 = 34'd652032874;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Data that rides along the rotator chain.
  typedef struct packed {
    logic                              neg;
    logic [31:0]                       vel_y;
    logic [31:0]                       vel_z;
    logic [NUM_PAIRS-1:0][TERM_W-1:0]  term;
  } fmrr_carry_t;

  // One word between rotator cells.
  typedef struct packed {
    logic [ANG_W-1:0] x;
    logic [ANG_W-1:0] y;
    logic [ANG_W-1:0] z;
    fmrr_carry_t      pl;
  } fmrr_cord_t;

endpackage

`default_nettype wire

### rtl/core/fmrr_prep.sv
// ----------------------------------------------------------------------------
// fmrr_prep
// Four-stage front end: pair terms of the mill readings and the binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrr_prep
  import fmrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [IN_W-1:0]  in_data_i,
  input  fmrr_cfg_t        cfg_i,
  output logic             hold_o,
  output logic             valid_o,
  output fmrr_cord_t       out_o,
  input  logic             hold_i
);

  logic va_q, vb_q, vc_q, vd_q;
  logic ha, hb, hc, hd;

  // A stage holds only when it is full and the one after it holds.
  assign hd     = vd_q & hold_i;
  assign hc     = vc_q & hd;
  assign hb     = vb_q & hc;
  assign ha     = va_q & hb;
  assign hold_o = ha;

  // Stage A: fold the angle and form the weighted differences.
  logic signed [16:0] r0, r1, r2;
  logic               fold_neg, ang_sgn;
  logic [16:0]        mag_w;
  logic [13:0]        mag;
  logic [30:0]        zhi_a;
  logic [27:0]        t_a;
  logic signed [48:0] d_a [NUM_PAIRS];
  logic signed [31:0] pa, pb;
  logic signed [15:0] ratio;
  logic signed [47:0] rb;

  always_comb begin
    r0 = {in_data_i[15], in_data_i[15:0]};
    r1 = r0;
    if (r0 > $signed(ANGLE_HALF)) begin
      r1 = r0 - $signed(ANGLE_FULL);
    end else if (r0 <= -$signed(ANGLE_HALF)) begin
      r1 = r0 + $signed(ANGLE_FULL);
    end
    r2       = r1;
    fold_neg = 1'b0;
    if (r1 > $signed(ANGLE_QUARTER)) begin
      r2       = r1 - $signed(ANGLE_HALF);
      fold_neg = 1'b1;
    end else if (r1 < -$signed(ANGLE_QUARTER)) begin
      r2       = r1 + $signed(ANGLE_HALF);
      fold_neg = 1'b1;
    end
    ang_sgn = r2[16];
    mag_w   = ang_sgn ? 17'(-r2) : 17'(r2);
    mag     = mag_w[13:0];
    zhi_a   = {17'd0, mag} * {14'd0, TURN_Q};
    t_a     = ({14'd0, mag} * {13'd0, TURN_R}) + {11'd0, ANGLE_HALF};
    for (int k = 0; k < NUM_PAIRS; k++) begin
      pa     = $signed(in_data_i[PAIR_A_LSB[k] +: 32]);
      pb     = $signed(in_data_i[PAIR_B_LSB[k] +: 32]);
      ratio  = $signed(cfg_i[2*k]);
      rb     = ratio * pb;
      d_a[k] = $signed({{5{pa[31]}}, pa, 12'd0}) - $signed({rb[47], rb});
    end
  end

  logic signed [48:0] d_q [NUM_PAIRS];
  logic [30:0]        zhi_a_q;
  logic [27:0]        t_a_q;
  logic               sgn_a_q, neg_a_q;
  logic [31:0]        vy_a_q, vz_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (!ha) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ha) begin
      d_q     <= d_a;
      zhi_a_q <= zhi_a;
      t_a_q   <= t_a;
      sgn_a_q <= ang_sgn;
      neg_a_q <= fold_neg;
      vy_a_q  <= in_data_i[47:16];
      vz_a_q  <= in_data_i[79:48];
    end
  end

  // Stage B: halve with rounding, apply the gain; estimate the quotient.
  logic signed [48:0] dr;
  logic signed [35:0] h;
  logic signed [15:0] gain;
  logic signed [51:0] pr_b [NUM_PAIRS];
  logic [52:0]        tm;
  logic [12:0]        q1_b;

  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      dr      = d_q[k] + 49'sd4096;
      h       = dr[48:13];
      gain    = $signed(cfg_i[2*k+1]);
      pr_b[k] = h * gain;
    end
    tm   = {25'd0, t_a_q} * {28'd0, RECIP_M};
    q1_b = tm[52:40];
  end

  logic signed [51:0] pr_q [NUM_PAIRS];
  logic [12:0]        q1_q;
  logic [27:0]        t_b_q;
  logic [30:0]        zhi_b_q;
  logic               sgn_b_q, neg_b_q;
  logic [31:0]        vy_b_q, vz_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (!hb) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hb) begin
      pr_q    <= pr_b;
      q1_q    <= q1_b;
      t_b_q   <= t_a_q;
      zhi_b_q <= zhi_a_q;
      sgn_b_q <= sgn_a_q;
      neg_b_q <= neg_a_q;
      vy_b_q  <= vy_a_q;
      vz_b_q  <= vz_a_q;
    end
  end

  // Stage C: round the pair terms; correct the quotient by one step.
  logic signed [51:0]       prr;
  logic [NUM_PAIRS-1:0][TERM_W-1:0] term_c;
  logic [27:0]              qm, rem;
  logic [12:0]              q_c;

  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      prr       = pr_q[k] + 52'sd2048;
      term_c[k] = prr[51:12];
    end
    qm  = {15'd0, q1_q} * {11'd0, ANGLE_FULL};
    rem = t_b_q - qm;
    q_c = q1_q + {12'd0, (rem >= {11'd0, ANGLE_FULL})};
  end

  logic [NUM_PAIRS-1:0][TERM_W-1:0] term_q;
  logic [12:0] q_q;
  logic [30:0] zhi_c_q;
  logic        sgn_c_q, neg_c_q;
  logic [31:0] vy_c_q, vz_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (!hc) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hc) begin
      term_q  <= term_c;
      q_q     <= q_c;
      zhi_c_q <= zhi_b_q;
      sgn_c_q <= sgn_b_q;
      neg_c_q <= neg_b_q;
      vy_c_q  <= vy_b_q;
      vz_c_q  <= vz_b_q;
    end
  end

  // Stage D: assemble the binary angle and seed the rotator.
  logic [30:0]      zmag;
  logic [ANG_W-1:0] zext;
  fmrr_cord_t       cord_d;

  always_comb begin
    zmag            = zhi_c_q + {18'd0, q_q};
    zext            = {3'b000, zmag};
    cord_d.x        = CORDIC_X0;
    cord_d.y        = '0;
    cord_d.z        = sgn_c_q ? (~zext + 1'b1) : zext;
    cord_d.pl.neg   = neg_c_q;
    cord_d.pl.vel_y = vy_c_q;
    cord_d.pl.vel_z = vz_c_q;
    cord_d.pl.term  = term_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (!hd) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hd) begin
      out_o <= cord_d;
    end
  end

  assign valid_o = vd_q;

endmodule

`default_nettype wire

### rtl/core/fmrr_cell.sv
// ----------------------------------------------------------------------------
// fmrr_cell
// One rotation-mode CORDIC iteration with its own pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrr_cell
  import fmrr_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  fmrr_cord_t in_i,
  output logic       hold_o,
  output logic       valid_o,
  output fmrr_cord_t out_o,
  input  logic       hold_i
);

  localparam logic [ANG_W-1:0] Atan = {2'b00, ATAN_TAB[Idx % 32]};

  logic       valid_q;
  fmrr_cord_t nxt;
  logic signed [ANG_W-1:0] xs, ys;
  logic       dir_pos;

  assign hold_o = valid_q & hold_i;

  // Rotate towards zero residual angle.
  always_comb begin
    xs      = $signed(in_i.x) >>> Idx;
    ys      = $signed(in_i.y) >>> Idx;
    dir_pos = ~in_i.z[ANG_W-1];
    nxt.pl  = in_i.pl;
    if (dir_pos) begin
      nxt.x = in_i.x - ys;
      nxt.y = in_i.y + xs;
      nxt.z = in_i.z - Atan;
    end else begin
      nxt.x = in_i.x + ys;
      nxt.y = in_i.y - xs;
      nxt.z = in_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      out_o <= nxt;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

### rtl/core/fmrr_rot.sv
// ----------------------------------------------------------------------------
// fmrr_rot
// Three-stage back end: sine and cosine rounding, products, sums with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrr_rot
  import fmrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  fmrr_cord_t       in_i,
  output logic             hold_o,
  output logic             out_valid_o,
  output logic [OUT_W-1:0] out_data_o,
  input  logic             out_ready_i
);

  localparam int unsigned NumRot = 3;

  logic v0_q, v1_q, v2_q;
  logic h0, h1, h2;

  assign h2     = v2_q & ~out_ready_i;
  assign h1     = v1_q & h2;
  assign h0     = v0_q & h1;
  assign hold_o = h0;

  // Stage 0: round cosine and sine to Q16 and undo the half-turn fold.
  logic signed [ANG_W-1:0] xr, yr;
  logic signed [CS_W-1:0]  c_d, s_d;
  logic signed [TERM_W-1:0] ay_d [NumRot];
  logic signed [TERM_W-1:0] az_d [NumRot];

  always_comb begin
    xr  = $signed(in_i.x) + 34'sd8192;
    yr  = $signed(in_i.y) + 34'sd8192;
    c_d = xr[ANG_W-1:14];
    s_d = yr[ANG_W-1:14];
    if (in_i.pl.neg) begin
      c_d = -c_d;
      s_d = -s_d;
    end
    ay_d[0] = {{8{in_i.pl.vel_y[31]}}, in_i.pl.vel_y};
    az_d[0] = {{8{in_i.pl.vel_z[31]}}, in_i.pl.vel_z};
    ay_d[1] = in_i.pl.term[0];
    az_d[1] = in_i.pl.term[1];
    ay_d[2] = in_i.pl.term[2];
    az_d[2] = in_i.pl.term[3];
  end

  logic signed [CS_W-1:0]   c_q, s_q;
  logic signed [TERM_W-1:0] ay_q [NumRot];
  logic signed [TERM_W-1:0] az_q [NumRot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (!h0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h0) begin
      c_q  <= c_d;
      s_q  <= s_d;
      ay_q <= ay_d;
      az_q <= az_d;
    end
  end

  // Stage 1: the four products of each pair.
  logic signed [59:0] pcy_d [NumRot];
  logic signed [59:0] psz_d [NumRot];
  logic signed [59:0] pcz_d [NumRot];
  logic signed [59:0] psy_d [NumRot];

  always_comb begin
    for (int j = 0; j < NumRot; j++) begin
      pcy_d[j] = c_q * ay_q[j];
      psz_d[j] = s_q * az_q[j];
      pcz_d[j] = c_q * az_q[j];
      psy_d[j] = s_q * ay_q[j];
    end
  end

  logic signed [59:0] pcy_q [NumRot];
  logic signed [59:0] psz_q [NumRot];
  logic signed [59:0] pcz_q [NumRot];
  logic signed [59:0] psy_q [NumRot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!h1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h1) begin
      pcy_q <= pcy_d;
      psz_q <= psz_d;
      pcz_q <= pcz_d;
      psy_q <= psy_d;
    end
  end

  // Stage 2: sums, rounding right by 16 and saturation into the output word.
  logic signed [61:0] sy, sz;
  logic signed [45:0] ry, rz;
  logic [OUT_W-1:0]   word_d;

  always_comb begin
    word_d = '0;
    for (int j = 0; j < NumRot; j++) begin
      sy = pcy_q[j] - psz_q[j] + 62'sd32768;
      sz = pcz_q[j] + psy_q[j] + 62'sd32768;
      ry = sy[61:16];
      rz = sz[61:16];
      if (ry > 46'sd2147483647) begin
        word_d[64*j +: 32] = 32'h7FFF_FFFF;
      end else if (ry < -46'sd2147483648) begin
        word_d[64*j +: 32] = 32'h8000_0000;
      end else begin
        word_d[64*j +: 32] = ry[31:0];
      end
      if (rz > 46'sd2147483647) begin
        word_d[64*j+32 +: 32] = 32'h7FFF_FFFF;
      end else if (rz < -46'sd2147483648) begin
        word_d[64*j+32 +: 32] = 32'h8000_0000;
      end else begin
        word_d[64*j+32 +: 32] = rz[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!h2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h2) begin
      out_data_o <= word_d;
    end
  end

  assign out_valid_o = v2_q;

endmodule

`default_nettype wire

### rtl/core/field_mill_roll_rotation.sv
// ----------------------------------------------------------------------------
// field_mill_roll_rotation
// Throughput: one word per cycle while the output is not stalled; four
// front-end stages, one CORDIC cell per step and three back-end stages, each
// with its own register.
// A full stage holds only while every stage after it is full and stalled.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "field_mill_roll_rotation_defines.svh"

module field_mill_roll_rotation
  import fmrr_pkg::*;
#(
  parameter int unsigned TRIG_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // roll_angle, vel_y, vel_z, field_top, field_bottom, field_port,
  // field_starboard, aux_top, aux_bottom, aux_port, aux_starboard
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vel_y_level, vel_z_level, field_y_level, field_z_level,
  // aux_y_level, aux_z_level
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  // Configuration registers; writes beyond the list are dropped.
  fmrr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        cfg_q[k] <= CFG_RESET[k];
      end
    end else if (cfg_we_i && (cfg_idx_i < REG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_idx_i[REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // Links of the rotator chain.
  fmrr_cord_t link_d [TRIG_STEPS+1];
  logic       link_v [TRIG_STEPS+1];
  logic       link_h [TRIG_STEPS+1];
  logic       prep_hold;

  fmrr_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .hold_o     (prep_hold),
    .valid_o    (link_v[0]),
    .out_o      (link_d[0]),
    .hold_i     (link_h[0])
  );

  assign s_axis_tready = ~prep_hold;

  for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_cell
    fmrr_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (link_v[g]),
      .in_i       (link_d[g]),
      .hold_o     (link_h[g]),
      .valid_o    (link_v[g+1]),
      .out_o      (link_d[g+1]),
      .hold_i     (link_h[g+1])
    );
  end

  fmrr_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (link_v[TRIG_STEPS]),
    .in_i        (link_d[TRIG_STEPS]),
    .hold_o      (link_h[TRIG_STEPS]),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

  // Back-pressure reaches the input only through a stalled, full output.
  `FMRR_ASSERT(a_ready_low_needs_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  `FMRR_ASSERT(a_chain_hold_needs_out, link_h[TRIG_STEPS] |-> m_axis_tvalid, "chain held with empty output")
  `FMRR_ASSERT_NORST(a_no_word_after_reset, !rst_ni |=> !m_axis_tvalid, "output word right after reset")

endmodule

`default_nettype wire
